@@ src/hsv_pkg.sv @@
package hsv_pkg;

   localparam logic [7:0] HUE_REGION_STEPS = 8'd43;
   localparam logic [7:0] HUE_FRAC_SCALE   = 8'd6;
   localparam logic [7:0] FULL_SCALE       = 8'hFF;

   typedef enum logic [2:0] {
      SEC_RED_TO_YEL = 3'd0,
      SEC_YEL_TO_GRN = 3'd1,
      SEC_GRN_TO_CYN = 3'd2,
      SEC_CYN_TO_BLU = 3'd3,
      SEC_BLU_TO_MAG = 3'd4,
      SEC_MAG_TO_RED = 3'd5
   } hue_sector_type;

   typedef struct packed {
      logic [7:0]     brightness;
      hue_sector_type sector;
      logic [7:0]     frac;
      logic [7:0]     sat;
      logic [7:0]     val;
   } prep_type;

   typedef struct packed {
      logic [7:0]     brightness;
      hue_sector_type sector;
      logic           grey;
      logic [7:0]     val;
      logic [7:0]     p_inner;
      logic [7:0]     q_inner;
      logic [7:0]     t_inner;
   } inner_type;

   typedef struct packed {
      logic [7:0]     brightness;
      hue_sector_type sector;
      logic           grey;
      logic [7:0]     val;
      logic [7:0]     p;
      logic [7:0]     q;
      logic [7:0]     t;
   } term_type;

   typedef struct packed {
      logic [7:0] brightness;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

endpackage

@@ src/hsv_prep.sv @@
module hsv_prep (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [7:0]        brightness,
   input  logic [7:0]        hue,
   input  logic [3:0]        sat_nibble,
   input  logic [3:0]        val_nibble,
   output logic              out_valid,
   input  logic              out_ready,
   output hsv_pkg::prep_type out_data
);
   import hsv_pkg::*;

   logic           valid_ff;
   prep_type       data_ff;
   prep_type       data_in;
   logic           advance;
   hue_sector_type sector;
   logic [7:0]     base;
   logic [5:0]     rem;

   assign advance = !valid_ff || out_ready;
   assign in_ready = advance;

   always_comb begin
      if (hue < HUE_REGION_STEPS) begin
         sector = SEC_RED_TO_YEL;
         base   = 8'd0;
      end else if (hue < 8'(2 * HUE_REGION_STEPS)) begin
         sector = SEC_YEL_TO_GRN;
         base   = 8'(HUE_REGION_STEPS);
      end else if (hue < 8'(3 * HUE_REGION_STEPS)) begin
         sector = SEC_GRN_TO_CYN;
         base   = 8'(2 * HUE_REGION_STEPS);
      end else if (hue < 8'(4 * HUE_REGION_STEPS)) begin
         sector = SEC_CYN_TO_BLU;
         base   = 8'(3 * HUE_REGION_STEPS);
      end else if (hue < 8'(5 * HUE_REGION_STEPS)) begin
         sector = SEC_BLU_TO_MAG;
         base   = 8'(4 * HUE_REGION_STEPS);
      end else begin
         sector = SEC_MAG_TO_RED;
         base   = 8'(5 * HUE_REGION_STEPS);
      end
   end

   assign rem = 6'(hue - base);

   always_comb begin
      data_in.brightness = brightness;
      data_in.sector     = sector;
      data_in.frac       = 8'({2'b00, rem} * HUE_FRAC_SCALE);
      data_in.sat        = {sat_nibble, sat_nibble};
      data_in.val        = {val_nibble, val_nibble};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ src/hsv_mult.sv @@
module hsv_mult (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  hsv_pkg::prep_type  in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output hsv_pkg::term_type  out_data
);
   import hsv_pkg::*;

   logic       inner_valid_ff;
   inner_type  inner_ff;
   inner_type  inner_in;
   logic       term_valid_ff;
   term_type   term_ff;
   term_type   term_in;
   logic       inner_advance;
   logic       term_advance;
   logic [15:0] sq_prod;
   logic [15:0] st_prod;
   logic [15:0] p_prod;
   logic [15:0] q_prod;
   logic [15:0] t_prod;

   assign term_advance  = !term_valid_ff || out_ready;
   assign inner_advance = !inner_valid_ff || term_advance;
   assign in_ready      = inner_advance;

   // inner terms: 255 - S, 255 - (S*f)>>8 and 255 - (S*(255-f))>>8
   assign sq_prod = {8'd0, in_data.sat} * {8'd0, in_data.frac};
   assign st_prod = {8'd0, in_data.sat} * {8'd0, FULL_SCALE - in_data.frac};

   always_comb begin
      inner_in.brightness = in_data.brightness;
      inner_in.sector     = in_data.sector;
      inner_in.grey       = (in_data.sat == 8'd0);
      inner_in.val        = in_data.val;
      inner_in.p_inner    = FULL_SCALE - in_data.sat;
      inner_in.q_inner    = FULL_SCALE - sq_prod[15:8];
      inner_in.t_inner    = FULL_SCALE - st_prod[15:8];
   end

   assign p_prod = {8'd0, inner_ff.val} * {8'd0, inner_ff.p_inner};
   assign q_prod = {8'd0, inner_ff.val} * {8'd0, inner_ff.q_inner};
   assign t_prod = {8'd0, inner_ff.val} * {8'd0, inner_ff.t_inner};

   always_comb begin
      term_in.brightness = inner_ff.brightness;
      term_in.sector     = inner_ff.sector;
      term_in.grey       = inner_ff.grey;
      term_in.val        = inner_ff.val;
      term_in.p          = p_prod[15:8];
      term_in.q          = q_prod[15:8];
      term_in.t          = t_prod[15:8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_valid_ff <= 1'b0;
         term_valid_ff  <= 1'b0;
      end else begin
         if (inner_advance) begin
            inner_valid_ff <= in_valid;
         end
         if (term_advance) begin
            term_valid_ff <= inner_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (inner_advance) begin
         inner_ff <= inner_in;
      end
      if (term_advance) begin
         term_ff <= term_in;
      end
   end

   assign out_valid = term_valid_ff;
   assign out_data  = term_ff;

endmodule

@@ src/hsv_route.sv @@
module hsv_route (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  hsv_pkg::term_type  in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output hsv_pkg::pixel_type out_data
);
   import hsv_pkg::*;

   logic      valid_ff;
   pixel_type pixel_ff;
   pixel_type pixel_in;
   logic      advance;

   assign advance  = !valid_ff || out_ready;
   assign in_ready = advance;

   always_comb begin
      pixel_in.brightness = in_data.brightness;
      if (in_data.grey) begin
         pixel_in.red   = in_data.val;
         pixel_in.green = in_data.val;
         pixel_in.blue  = in_data.val;
      end else begin
         case (in_data.sector)
            SEC_RED_TO_YEL: begin
               pixel_in.red   = in_data.val;
               pixel_in.green = in_data.t;
               pixel_in.blue  = in_data.p;
            end
            SEC_YEL_TO_GRN: begin
               pixel_in.red   = in_data.q;
               pixel_in.green = in_data.val;
               pixel_in.blue  = in_data.p;
            end
            SEC_GRN_TO_CYN: begin
               pixel_in.red   = in_data.p;
               pixel_in.green = in_data.val;
               pixel_in.blue  = in_data.t;
            end
            SEC_CYN_TO_BLU: begin
               pixel_in.red   = in_data.p;
               pixel_in.green = in_data.q;
               pixel_in.blue  = in_data.val;
            end
            SEC_BLU_TO_MAG: begin
               pixel_in.red   = in_data.t;
               pixel_in.green = in_data.p;
               pixel_in.blue  = in_data.val;
            end
            default: begin
               pixel_in.red   = in_data.val;
               pixel_in.green = in_data.p;
               pixel_in.blue  = in_data.q;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pixel_ff <= pixel_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = pixel_ff;

endmodule

@@ src/hsv_to_rgb_pixel_convert.sv @@
// HSV to RGB pixel converter for LED pixel words.
// Input channel req_*: brightness byte, 8-bit hue, 4-bit saturation and
// 4-bit value; a transfer happens when req_valid and req_ready are high.
// Output channel rsp_*: brightness byte copied through, then blue, green, red.
// Saturation and value are widened by nibble repetition; zero saturation
// gives grey at the value level.
// Four register stages (sector/fraction, inner terms, products, channel
// routing). Throughput: one pixel per clock while rsp_ready keeps the
// output moving; the two middle stages each hold one 8x8 multiply level.
// Every stage has its own valid bit and takes new data whenever it is empty
// or its successor moves, so bubbles are squeezed out during a stall.
// When rsp_ready is low the output holds steady and the pipe fills up; at
// most four pixels are held before req_ready drops.
// Reset (synchronous, active high) empties all stages; no pixel survives it.
module hsv_to_rgb_pixel_convert (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_brightness_in,
   input  logic [7:0] req_hue,
   input  logic [3:0] req_sat_nibble,
   input  logic [3:0] req_val_nibble,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_brightness_out,
   output logic [7:0] rsp_blue,
   output logic [7:0] rsp_green,
   output logic [7:0] rsp_red
);
   import hsv_pkg::*;

   prep_type  prep_data;
   logic      prep_valid;
   logic      prep_ready;
   term_type  term_data;
   logic      term_valid;
   logic      term_ready;
   pixel_type pixel;

   hsv_prep u_prep (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .brightness (req_brightness_in),
      .hue        (req_hue),
      .sat_nibble (req_sat_nibble),
      .val_nibble (req_val_nibble),
      .out_valid  (prep_valid),
      .out_ready  (prep_ready),
      .out_data   (prep_data)
   );

   hsv_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_ready  (prep_ready),
      .in_data   (prep_data),
      .out_valid (term_valid),
      .out_ready (term_ready),
      .out_data  (term_data)
   );

   hsv_route u_route (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (term_valid),
      .in_ready  (term_ready),
      .in_data   (term_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (pixel)
   );

   assign rsp_brightness_out = pixel.brightness;
   assign rsp_blue           = pixel.blue;
   assign rsp_green          = pixel.green;
   assign rsp_red            = pixel.red;

endmodule

@@ src/hsv_checker.sv @@
module hsv_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_brightness_in,
   input logic [7:0] req_hue,
   input logic [3:0] req_sat_nibble,
   input logic [3:0] req_val_nibble,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_brightness_out,
   input logic [7:0] rsp_blue,
   input logic [7:0] rsp_green,
   input logic [7:0] rsp_red
);

   // reset empties the pipe
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a free output slot always propagates back to the input
   a_ready_chain: assert property (@(posedge clock)
      (rsp_ready || !rsp_valid) |-> req_ready)
      else $error("req_ready low with output free");

   // the brightest channel is the widened value, a repeated nibble
   a_val_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_red[7:4] == rsp_red[3:0]) ||
                    (rsp_green[7:4] == rsp_green[3:0]) ||
                    (rsp_blue[7:4] == rsp_blue[3:0]))
      else $error("no channel carries the value level");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_brightness_out) &&
         $stable(rsp_blue) && $stable(rsp_green) && $stable(rsp_red)))
      else $error("stalled result changed");

   // a waiting request keeps its payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_ready) |=> (req_valid && $stable(req_brightness_in) &&
         $stable(req_hue) && $stable(req_sat_nibble) && $stable(req_val_nibble)))
      else $error("stalled request changed");

endmodule

bind hsv_to_rgb_pixel_convert hsv_checker u_hsv_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .req_brightness_in  (req_brightness_in),
   .req_hue            (req_hue),
   .req_sat_nibble     (req_sat_nibble),
   .req_val_nibble     (req_val_nibble),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_brightness_out (rsp_brightness_out),
   .rsp_blue           (rsp_blue),
   .rsp_green          (rsp_green),
   .rsp_red            (rsp_red)
);

@@ test/hsv_to_rgb_pixel_convert_tb.sv @@
`timescale 1ns / 100ps

module hsv_to_rgb_pixel_convert_tb;
   import hsv_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 12;
   localparam int MAX_REPORTS    = 40;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_brightness_in = 8'd0;
   logic [7:0] req_hue = 8'd0;
   logic [3:0] req_sat_nibble = 4'd0;
   logic [3:0] req_val_nibble = 4'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_brightness_out;
   logic [7:0] rsp_blue;
   logic [7:0] rsp_green;
   logic [7:0] rsp_red;

   pixel_type expected_pixels[$];
   pixel_type wanted;
   int        mismatches = 0;
   int        n_sent = 0;
   int        n_checked = 0;
   int        n_grey = 0;
   int        send_idle_pct = 0;
   int        recv_idle_pct = 0;
   int        hold_asks = 0;
   int        hold_served = 0;
   int        hold_left = 0;
   int        quiet_cycles = 0;

   hsv_to_rgb_pixel_convert i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_brightness_in  (req_brightness_in),
      .req_hue            (req_hue),
      .req_sat_nibble     (req_sat_nibble),
      .req_val_nibble     (req_val_nibble),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_brightness_out (rsp_brightness_out),
      .rsp_blue           (rsp_blue),
      .rsp_green          (rsp_green),
      .rsp_red            (rsp_red)
   );

   always #5 clock = ~clock;

   function automatic int shade_term(input int v, input int s, input int f);
      return (v * (255 - ((s * f) >> 8))) >> 8;
   endfunction

   function automatic pixel_type predict_rgb(input logic [7:0] bri, input logic [7:0] hue,
                                             input logic [3:0] sat_n, input logic [3:0] val_n);
      int             s;
      int             v;
      int             sec_idx;
      int             frac;
      int             p;
      int             q;
      int             t;
      hue_sector_type sector;
      pixel_type      px;
      s = int'(sat_n) * 17;
      v = int'(val_n) * 17;
      px.brightness = bri;
      if (s == 0) begin
         px.red   = 8'(v);
         px.green = 8'(v);
         px.blue  = 8'(v);
      end else begin
         sec_idx = int'(hue) / int'(HUE_REGION_STEPS);
         frac    = (int'(hue) - sec_idx * int'(HUE_REGION_STEPS)) * int'(HUE_FRAC_SCALE);
         sector  = hue_sector_type'(sec_idx[2:0]);
         p = (v * (int'(FULL_SCALE) - s)) >> 8;
         q = shade_term(v, s, frac);
         t = shade_term(v, s, int'(FULL_SCALE) - frac);
         case (sector)
            SEC_RED_TO_YEL: begin
               px.red = 8'(v); px.green = 8'(t); px.blue = 8'(p);
            end
            SEC_YEL_TO_GRN: begin
               px.red = 8'(q); px.green = 8'(v); px.blue = 8'(p);
            end
            SEC_GRN_TO_CYN: begin
               px.red = 8'(p); px.green = 8'(v); px.blue = 8'(t);
            end
            SEC_CYN_TO_BLU: begin
               px.red = 8'(p); px.green = 8'(q); px.blue = 8'(v);
            end
            SEC_BLU_TO_MAG: begin
               px.red = 8'(t); px.green = 8'(p); px.blue = 8'(v);
            end
            default: begin
               px.red = 8'(v); px.green = 8'(p); px.blue = 8'(q);
            end
         endcase
      end
      return px;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want_v);
      if (mismatches < MAX_REPORTS) begin
         $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want_v);
      end
      mismatches++;
   endtask

   // scoreboard: predict on input transfer, compare on output transfer
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_pixels.push_back(predict_rgb(req_brightness_in, req_hue,
                                                  req_sat_nibble, req_val_nibble));
            if (req_sat_nibble == 4'd0) begin
               n_grey++;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch("pixel with none pending, red", rsp_red, -1);
            end else begin
               wanted = expected_pixels.pop_front();
               if (rsp_brightness_out != wanted.brightness) begin
                  report_mismatch("brightness", rsp_brightness_out, wanted.brightness);
               end
               if (rsp_blue != wanted.blue) begin
                  report_mismatch("blue", rsp_blue, wanted.blue);
               end
               if (rsp_green != wanted.green) begin
                  report_mismatch("green", rsp_green, wanted.green);
               end
               if (rsp_red != wanted.red) begin
                  report_mismatch("red", rsp_red, wanted.red);
               end
               n_checked++;
            end
         end
      end
   end

   // output side: random stalls plus long holds on request
   always @(negedge clock) begin
      if (hold_asks != hold_served) begin
         hold_served = hold_asks;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   task automatic send_pixel(input logic [7:0] bri, input logic [7:0] hue,
                             input logic [3:0] sat_n, input logic [3:0] val_n);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid         = 1'b1;
      req_brightness_in = bri;
      req_hue           = hue;
      req_sat_nibble    = sat_n;
      req_val_nibble    = val_n;
      do @(posedge clock); while (!req_ready);
      n_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic send_random_pixel();
      send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                 4'($urandom_range(15)), 4'($urandom_range(15)));
   endtask

   task automatic test_directed();
      logic [7:0] sector_edges[12];
      sector_edges = '{8'd0, 8'd42, 8'd43, 8'd85, 8'd86, 8'd128,
                       8'd129, 8'd171, 8'd172, 8'd214, 8'd215, 8'd255};
      send_pixel(8'h00, 8'h00, 4'h0, 4'h0);
      send_pixel(8'hFF, 8'hFF, 4'hF, 4'hF);
      // grey: zero saturation ignores hue
      send_pixel(8'hA5, 8'h7E, 4'h0, 4'hF);
      send_pixel(8'h5A, 8'hFF, 4'h0, 4'h9);
      send_pixel(8'h3C, 8'h81, 4'h0, 4'h1);
      foreach (sector_edges[i]) begin
         send_pixel(8'(i * 21), sector_edges[i], 4'hF, 4'hF);
      end
      // the first two hues land in the last sector, the rest in earlier ones
      send_pixel(8'h01, 8'd230, 4'h8, 4'hC);
      send_pixel(8'h80, 8'd250, 4'h1, 4'h1);
      send_pixel(8'hC3, 8'd21, 4'h1, 4'hF);
      send_pixel(8'h18, 8'd100, 4'hF, 4'h1);
      send_pixel(8'hE7, 8'd150, 4'h7, 4'h0);
      send_pixel(8'h42, 8'd190, 4'hA, 4'h5);
   endtask

   task automatic test_random(input int count);
      repeat (count) send_random_pixel();
   endtask

   task automatic test_output_hold();
      @(posedge clock);
      hold_asks++;
      @(negedge clock);
      repeat (30) send_random_pixel();
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 9;
      recv_idle_pct = 80;
      test_directed();
      test_random(260);
      test_output_hold();

      send_idle_pct = 80;
      recv_idle_pct = 9;
      test_random(260);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(260);
      wait_drained();

      $display("covered %0d pixels sent, %0d compared, %0d of them grey",
               n_sent, n_checked, n_grey);
      $display("idle mixes: slow output, slow input, none; one long output stall");
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
